// ----- hw/rtl/bhc_pkg.sv -----
// shared types and constants of the band handle cache
`timescale 1ns / 1ps

package bhc_pkg;

  // stream payload widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int DRIVE_W     = 3;
  localparam int BAND_W      = 32;
  localparam int OUT_SLOT_W  = 4;
  localparam int MASK_W      = 16;

  // slot status, ordered so that a higher code satisfies a lower need
  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_MISSING = 2'd1,
    ST_FILE    = 2'd2
  } status_t;

  // request kind carried in tuser
  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_CLOSE  = 1'b1
  } kind_t;

  // backing store answer on a miss
  localparam logic [1:0] OPEN_OK      = 2'd0;
  localparam logic [1:0] OPEN_MISSING = 2'd1;

  // result outcome codes
  localparam logic [1:0] OC_HIT   = 2'd0;
  localparam logic [1:0] OC_FILL  = 2'd1;
  localparam logic [1:0] OC_ERROR = 2'd2;

  // one registered request
  typedef struct packed {
    kind_t               kind;
    logic [DRIVE_W-1:0]  drive;
    logic [BAND_W-1:0]   band;
    logic                want_write;
    logic [1:0]          open_outcome;
  } req_t;

  // one result item
  typedef struct packed {
    logic [1:0]            outcome;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  has_file;
    logic                  close_old;
    logic [MASK_W-1:0]     closed_mask;
  } res_t;

  // slot store update command
  typedef struct packed {
    logic               fill;
    logic               clear;
    status_t            new_status;
    logic [DRIVE_W-1:0] drive;
    logic [BAND_W-1:0]  band;
  } upd_t;

endpackage

// ----- hw/rtl/bhc_tags.sv -----
// slot store: status, drive and band tags with per-slot compare
`timescale 1ns / 1ps

module bhc_tags #(
  parameter int SLOTS  = 16,
  parameter int SLOT_W = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  bhc_pkg::upd_t                 upd,
  input  logic [SLOT_W-1:0]             victim,
  input  logic [SLOTS-1:0]              clear_vec,
  input  logic [bhc_pkg::DRIVE_W-1:0]   req_drive,
  input  logic [bhc_pkg::BAND_W-1:0]    req_band,
  output bhc_pkg::status_t [SLOTS-1:0]  status,
  output logic [SLOTS-1:0]              drive_eq,
  output logic [SLOTS-1:0]              full_eq
);
  import bhc_pkg::*;

  status_t [SLOTS-1:0]  status_r;
  logic [DRIVE_W-1:0]   drive_r [SLOTS];
  logic [BAND_W-1:0]    band_r [SLOTS];

  assign status = status_r;

  // compare lanes, only live slots count
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      drive_eq[i] = (status_r[i] != ST_EMPTY) && (drive_r[i] == req_drive);
      full_eq[i]  = drive_eq[i] && (band_r[i] == req_band);
    end
  end

  // status update: fill one slot or clear a set of slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '{default: ST_EMPTY};
    end else if (en) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (upd.clear && clear_vec[i]) begin
          status_r[i] <= ST_EMPTY;
        end else if (upd.fill && (victim == SLOT_W'(i))) begin
          status_r[i] <= upd.new_status;
        end
      end
    end
  end

  // tag write on fill
  always_ff @(posedge clk) begin
    if (en && upd.fill) begin
      drive_r[victim] <= upd.drive;
      band_r[victim]  <= upd.band;
    end
  end

endmodule

// ----- hw/rtl/bhc_decide.sv -----
// lookup and close decision from the compare results
`timescale 1ns / 1ps

module bhc_decide #(
  parameter int SLOTS  = 16,
  parameter int DRIVES = 8,
  parameter int SLOT_W = 4
) (
  input  bhc_pkg::req_t                 req,
  input  bhc_pkg::status_t [SLOTS-1:0]  status,
  input  logic [SLOTS-1:0]              drive_eq,
  input  logic [SLOTS-1:0]              full_eq,
  input  logic [SLOT_W-1:0]             ptr,
  output bhc_pkg::res_t                 res,
  output bhc_pkg::upd_t                 upd,
  output logic [SLOT_W-1:0]             victim,
  output logic [SLOTS-1:0]              clear_vec,
  output logic                          ptr_adv
);
  import bhc_pkg::*;

  logic                 drive_ok;
  logic                 found;
  logic [SLOT_W-1:0]    found_idx;
  status_t              found_st;
  status_t              need;
  status_t              new_st;
  logic                 open_fail;
  logic                 hit;
  logic                 old_file;
  logic [SLOT_W+3:0]    slot_ext;
  logic [SLOT_W+3:0]    found_ext;

  assign drive_ok = 32'(req.drive) < 32'(DRIVES);

  // first matching slot, lowest index wins
  always_comb begin
    found_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (full_eq[i]) begin
        found_idx = SLOT_W'(i);
      end
    end
  end

  assign found    = |full_eq;
  assign found_st = status[found_idx];
  assign need     = req.want_write ? ST_FILE : ST_MISSING;
  assign hit      = found && (found_st >= need);

  // status to fill with, or an open failure
  always_comb begin
    new_st    = ST_FILE;
    open_fail = 1'b0;
    if (req.open_outcome == OPEN_OK) begin
      new_st = ST_FILE;
    end else if ((req.open_outcome == OPEN_MISSING) && !req.want_write) begin
      new_st = ST_MISSING;
    end else begin
      open_fail = 1'b1;
    end
  end

  // victim: refill a weak match in place, else the round-robin slot
  assign victim    = found ? found_idx : ptr;
  assign old_file  = status[victim] == ST_FILE;
  assign slot_ext  = {4'b0, victim};
  assign found_ext = {4'b0, found_idx};

  // close vector
  assign clear_vec = drive_ok ? drive_eq : '0;

  // result and update
  always_comb begin
    res            = '0;
    upd.fill       = 1'b0;
    upd.clear      = 1'b0;
    upd.new_status = new_st;
    upd.drive      = req.drive;
    upd.band       = req.band;
    ptr_adv        = 1'b0;
    if (req.kind == KIND_CLOSE) begin
      upd.clear = 1'b1;
      res.outcome = OC_HIT;
      for (int i = 0; i < MASK_W; i++) begin
        if (i < SLOTS) begin
          res.closed_mask[i] = clear_vec[i];
        end
      end
    end else if (!drive_ok) begin
      res.outcome = OC_ERROR;
    end else if (hit) begin
      res.outcome  = OC_HIT;
      res.slot     = found_ext[OUT_SLOT_W-1:0];
      res.has_file = found_st == ST_FILE;
    end else if (open_fail) begin
      res.outcome = OC_ERROR;
    end else begin
      upd.fill      = 1'b1;
      ptr_adv       = !found;
      res.outcome   = OC_FILL;
      res.slot      = slot_ext[OUT_SLOT_W-1:0];
      res.has_file  = new_st == ST_FILE;
      res.close_old = old_file;
    end
  end

endmodule

// ----- hw/rtl/band_handle_cache_round_robin_core.sv -----
// top level of the band handle cache with round-robin replacement
`timescale 1ns / 1ps

// Fully associative cache of band handles. A lookup or close item is
// accepted into an input register; once the output register can take a
// result, its drive and band are compared against every slot at once, the
// slot store and the round-robin pointer are updated and the result lands in
// the output register. One item is taken per cycle while the output is not
// stalled. The compare across all SLOTS tag lanes is combinational, which
// lets each item see the store as the item before left it. A stalled result
// holds the output register and, once the input register is also full,
// in_tready drops. No clearing pass after reset: all slots read empty at once.

module band_handle_cache_round_robin_core #(
  parameter int SLOTS  = 16,
  parameter int DRIVES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // drive[2:0], band_index[34:3], want_write[35], open_outcome[37:36], zero pad
  input  logic [bhc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // kind[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // outcome[1:0], slot[5:2], has_file[6], close_old[7], closed_mask[23:8]
  output logic [bhc_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import bhc_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);

  logic                 in_valid_r;
  req_t                 req_r;
  logic                 out_valid_r;
  res_t                 res_r;
  logic [SLOT_W-1:0]    ptr_r;
  logic [SLOT_W-1:0]    ptr_nxt;
  logic                 advance;
  logic                 proc;
  status_t [SLOTS-1:0]  status;
  logic [SLOTS-1:0]     drive_eq;
  logic [SLOTS-1:0]     full_eq;
  logic [SLOTS-1:0]     clear_vec;
  logic [SLOT_W-1:0]    victim;
  logic                 ptr_adv;
  res_t                 res;
  upd_t                 upd;

  // handshake
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign proc      = in_valid_r && advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.closed_mask, res_r.close_old, res_r.has_file,
                       res_r.slot, res_r.outcome};

  // round-robin pointer wrap
  assign ptr_nxt = (ptr_r == SLOT_W'(SLOTS - 1)) ? '0 : ptr_r + 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (proc && ptr_adv) begin
        ptr_r <= ptr_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r.kind         <= kind_t'(in_tuser);
      req_r.drive        <= in_tdata[2:0];
      req_r.band         <= in_tdata[34:3];
      req_r.want_write   <= in_tdata[35];
      req_r.open_outcome <= in_tdata[37:36];
    end
    if (proc) begin
      res_r <= res;
    end
  end

  bhc_tags #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_tags (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (proc),
    .upd       (upd),
    .victim    (victim),
    .clear_vec (clear_vec),
    .req_drive (req_r.drive),
    .req_band  (req_r.band),
    .status    (status),
    .drive_eq  (drive_eq),
    .full_eq   (full_eq)
  );

  bhc_decide #(
    .SLOTS  (SLOTS),
    .DRIVES (DRIVES),
    .SLOT_W (SLOT_W)
  ) u_decide (
    .req       (req_r),
    .status    (status),
    .drive_eq  (drive_eq),
    .full_eq   (full_eq),
    .ptr       (ptr_r),
    .res       (res),
    .upd       (upd),
    .victim    (victim),
    .clear_vec (clear_vec),
    .ptr_adv   (ptr_adv)
  );

endmodule

// ----- hw/rtl/bhc_checker.sv -----
// port-level checks of the band handle cache, bound to the top level
`timescale 1ns / 1ps

module bhc_port_props (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bhc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import bhc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an error result carries no slot, file or mask
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == OC_ERROR) |-> (out_tdata[23:2] == '0))
    else $error("error result with stray fields");

  // only a close reports emptied slots, with slot and file fields clear
  a_close_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[23:8] != '0) |->
      (out_tdata[1:0] == OC_HIT) && (out_tdata[7:2] == '0))
    else $error("closed mask on a lookup result");

  // a hit never replaces an open file
  a_hit_no_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == OC_HIT) |-> !out_tdata[7])
    else $error("close_old set on a hit");

endmodule

bind band_handle_cache_round_robin_core bhc_port_props u_bhc_port_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
